FILE: rtl/sust_pkg.sv
// Shared types and codes for the sorted set table.
// Used by sust_ctrl, sust_dp and sorted_unique_set_table_unit; depends on nothing.
`default_nettype none

package sust_pkg;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_DEL = 2'd1;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               was_present;
		logic [4:0]         entry_count;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
		logic               is_empty;
		logic               add_rejected;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic load;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sust_ctrl.sv
// Controller state machine for the sorted set table.
// Depends on sust_pkg for the command struct; drives the handshakes and sust_dp.
`default_nettype none

module sust_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sust_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) || ((state_q == ST_RESULT) && slot_free);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	assign cmd.capture = accept;
	assign cmd.update  = (state_q == ST_UPDATE);
	assign cmd.load    = (state_q == ST_RESULT) && slot_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) begin
					state_d = accept ? ST_UPDATE : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> rsp_valid)
		else $error("result load did not raise rsp_valid");
	a_capture_updates: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_UPDATE))
		else $error("accepted request did not enter the update state");
	a_update_results: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (state_q == ST_RESULT))
		else $error("update state not followed by result state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> !req_ready)
		else $error("request accepted during update");
`endif

endmodule

`default_nettype wire

FILE: rtl/sust_dp.sv
// Datapath for the sorted set table: entry cells, fill count and result register.
// Depends on sust_pkg; commanded by sust_ctrl.
`default_nettype none

module sust_dp #(
	parameter int CAPACITY = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sust_pkg::cmd_t cmd,
	input  wire sust_pkg::req_t req,
	output sust_pkg::rsp_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic signed [31:0] entries_q [CAPACITY];
	logic signed [31:0] lower_nb  [CAPACITY];
	logic signed [31:0] upper_nb  [CAPACITY];
	logic [CW-1:0]      count_q;
	sust_pkg::req_t     req_q;
	sust_pkg::rsp_t     rsp_q;
	logic               was_present_q;
	logic               rejected_q;
	logic [CAPACITY-1:0] less;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] ins_here;
	logic               present;
	logic               full;
	logic               do_add;
	logic               do_del;
	logic [IW-1:0]      last_idx;
	logic [4:0]         count_ext;

	assign ins_here = {less[CAPACITY-2:0], 1'b1};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic valid;
		assign valid   = CW'(i) < count_q;
		assign less[i] = valid && (entries_q[i] < req_q.value);
		assign eq[i]   = valid && (entries_q[i] == req_q.value);
		if (i == 0) begin : g_first
			assign lower_nb[i] = req_q.value;
		end else begin : g_lower
			assign lower_nb[i] = entries_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_nb[i] = entries_q[i];
		end else begin : g_upper
			assign upper_nb[i] = entries_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.update && !less[i]) begin
				if (do_add) begin
					entries_q[i] <= ins_here[i] ? req_q.value : lower_nb[i];
				end else if (do_del) begin
					entries_q[i] <= upper_nb[i];
				end
			end
		end
	end

	assign present = |eq;
	assign full    = (count_q == CW'(CAPACITY));

	always_comb begin
		do_add = 1'b0;
		do_del = 1'b0;
		case (req_q.action)
			sust_pkg::ACT_ADD: begin
				do_add = !present && !full;
			end
			sust_pkg::ACT_DEL: begin
				do_del = present;
			end
			default: begin
				do_add = 1'b0;
			end
		endcase
	end

	assign last_idx  = IW'(count_q - CW'(1));
	assign count_ext = 5'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			if (do_add) begin
				count_q <= count_q + CW'(1);
			end else if (do_del) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.update) begin
			was_present_q <= present;
			rejected_q    <= (req_q.action == sust_pkg::ACT_ADD) && !present && full;
		end
		if (cmd.load) begin
			rsp_q.was_present  <= was_present_q;
			rsp_q.entry_count  <= count_ext;
			rsp_q.is_empty     <= (count_q == '0);
			rsp_q.add_rejected <= rejected_q;
			if (count_q == '0) begin
				rsp_q.min_value <= '0;
				rsp_q.max_value <= '0;
			end else begin
				rsp_q.min_value <= entries_q[0];
				rsp_q.max_value <= entries_q[last_idx];
			end
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count exceeds capacity");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && do_add) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the fill count");
	a_lookup_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !do_add && !do_del) |=> $stable(count_q))
		else $error("fill count changed without insert or removal");
`endif

endmodule

`default_nettype wire

FILE: rtl/sorted_unique_set_table_unit.sv
// Top level of the sorted set table: joins the controller and the datapath.
// Depends on sust_pkg, sust_ctrl and sust_dp.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order and
// answers one add, delete or lookup per request with one response. Each
// request passes through the update and result states. In the update state,
// every entry cell compares itself with the value in parallel and the cells
// shift up or down in place; in the result state, the minimum and maximum
// are read out into the response register. A new request is taken in the
// result state, so back-to-back requests overlap while responses are drained
// promptly; a stalled response holds the block after the next request has
// been updated. No clearing pass after reset; a full-table add is flagged and dropped.
`default_nettype none

module sorted_unique_set_table_unit #(
	parameter int CAPACITY = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sust_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sust_pkg::rsp_t      rsp
);

	sust_pkg::cmd_t cmd;

	sust_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	sust_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
